// ----- sv/tac_pkg.sv -----
// ----------------------------------------------------------------------------
// tac_pkg
// Shared types and topology codes for triangle assembly and culling.
// ----------------------------------------------------------------------------
package tac_pkg;

    typedef logic [1:0] t_mode;

    localparam t_mode TOPO_LIST  = 2'd0;
    localparam t_mode TOPO_STRIP = 2'd1;
    localparam t_mode TOPO_FAN   = 2'd2;

    localparam int unsigned SEEN_FULL  = 2;
    localparam int unsigned PHASE_LAST = 2;

endpackage

// ----- sv/tac_assemble.sv -----
// ----------------------------------------------------------------------------
// tac_assemble
// Vertex history, batch counters and triangle selection. Registers the edge
// differences and tags of each formed triangle.
// ----------------------------------------------------------------------------
module tac_assemble #(
    parameter int COORD_BITS = 16,
    parameter int TAG_BITS   = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  tac_pkg::t_mode              i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic [TAG_BITS-1:0]         i_vertex_tag,
    input  logic                        i_restart,
    output logic                        o_s1_valid,
    input  logic                        i_s1_ready,
    output logic signed [COORD_BITS:0]  o_d1,
    output logic signed [COORD_BITS:0]  o_d2,
    output logic signed [COORD_BITS:0]  o_d3,
    output logic signed [COORD_BITS:0]  o_d4,
    output logic [TAG_BITS-1:0]         o_tag_a,
    output logic [TAG_BITS-1:0]         o_tag_b,
    output logic [TAG_BITS-1:0]         o_tag_c
);
    import tac_pkg::*;

    localparam int DW = COORD_BITS + 1;

    t_mode                   r_mode;
    logic [1:0]              r_seen;
    logic [1:0]              r_phase;
    logic                    r_parity;
    logic signed [COORD_BITS-1:0] r_older_x, r_older_y;
    logic signed [COORD_BITS-1:0] r_newer_x, r_newer_y;
    logic signed [COORD_BITS-1:0] r_anchor_x, r_anchor_y;
    logic [TAG_BITS-1:0]     r_older_tag, r_newer_tag, r_anchor_tag;
    logic                    r_s1_valid;
    logic signed [DW-1:0]    r_d1, r_d2, r_d3, r_d4;
    logic [TAG_BITS-1:0]     r_tag_a, r_tag_b, r_tag_c;

    logic [1:0]              seen;
    logic [1:0]              phase;
    logic                    parity;
    logic                    full;
    logic                    formed;
    logic                    accept;
    logic signed [COORD_BITS-1:0] ax, ay, bx, by;
    logic [TAG_BITS-1:0]     atag, btag;

    assign o_ready = !r_s1_valid || i_s1_ready;
    assign accept  = i_valid && o_ready;

    // apply restart before the vertex is used
    assign seen   = i_restart ? 2'd0 : r_seen;
    assign phase  = i_restart ? 2'd0 : r_phase;
    assign parity = i_restart ? 1'b0 : r_parity;
    assign full   = (seen == 2'(SEEN_FULL));

    always_comb begin
        formed = 1'b0;
        ax     = r_older_x;
        ay     = r_older_y;
        atag   = r_older_tag;
        bx     = r_newer_x;
        by     = r_newer_y;
        btag   = r_newer_tag;
        unique case (r_mode)
            TOPO_LIST: begin
                formed = full && (phase == 2'(PHASE_LAST));
            end
            TOPO_STRIP: begin
                formed = full;
                if (parity) begin
                    ax   = r_newer_x;
                    ay   = r_newer_y;
                    atag = r_newer_tag;
                    bx   = r_older_x;
                    by   = r_older_y;
                    btag = r_older_tag;
                end
            end
            TOPO_FAN: begin
                formed = full;
                ax     = r_anchor_x;
                ay     = r_anchor_y;
                atag   = r_anchor_tag;
            end
            default: begin
                formed = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= TOPO_LIST;
            r_seen   <= 2'd0;
            r_phase  <= 2'd0;
            r_parity <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (accept) begin
                r_parity <= full ? !parity : parity;
                r_phase  <= (phase >= 2'(PHASE_LAST)) ? 2'd0 : phase + 2'd1;
                r_seen   <= full ? seen : seen + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (seen == 2'd0) begin
                r_anchor_x   <= i_pos_x;
                r_anchor_y   <= i_pos_y;
                r_anchor_tag <= i_vertex_tag;
            end
            r_older_x   <= r_newer_x;
            r_older_y   <= r_newer_y;
            r_older_tag <= r_newer_tag;
            r_newer_x   <= i_pos_x;
            r_newer_y   <= i_pos_y;
            r_newer_tag <= i_vertex_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= accept && formed;
        end
    end

    // edge differences: (b-a).x, (c-a).y, (b-a).y, (c-a).x
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_d1    <= DW'(bx) - DW'(ax);
            r_d2    <= DW'(i_pos_y) - DW'(ay);
            r_d3    <= DW'(by) - DW'(ay);
            r_d4    <= DW'(i_pos_x) - DW'(ax);
            r_tag_a <= atag;
            r_tag_b <= btag;
            r_tag_c <= i_vertex_tag;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_d1       = r_d1;
    assign o_d2       = r_d2;
    assign o_d3       = r_d3;
    assign o_d4       = r_d4;
    assign o_tag_a    = r_tag_a;
    assign o_tag_b    = r_tag_b;
    assign o_tag_c    = r_tag_c;

endmodule

// ----- sv/tac_cull.sv -----
// ----------------------------------------------------------------------------
// tac_cull
// Cross product of the triangle edges and back-face test. Products are
// registered, then compared; kept triangles go to the result register.
// ----------------------------------------------------------------------------
module tac_cull #(
    parameter int COORD_BITS = 16,
    parameter int TAG_BITS   = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s1_valid,
    output logic                        o_s1_ready,
    input  logic signed [COORD_BITS:0]  i_d1,
    input  logic signed [COORD_BITS:0]  i_d2,
    input  logic signed [COORD_BITS:0]  i_d3,
    input  logic signed [COORD_BITS:0]  i_d4,
    input  logic [TAG_BITS-1:0]         i_tag_a,
    input  logic [TAG_BITS-1:0]         i_tag_b,
    input  logic [TAG_BITS-1:0]         i_tag_c,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [TAG_BITS-1:0]         o_tag_a,
    output logic [TAG_BITS-1:0]         o_tag_b,
    output logic [TAG_BITS-1:0]         o_tag_c
);
    import tac_pkg::*;

    localparam int PW = 2 * (COORD_BITS + 1);

    logic                 r_s2_valid;
    logic signed [PW-1:0] r_p;
    logic signed [PW-1:0] r_q;
    logic [TAG_BITS-1:0]  r_s2_tag_a, r_s2_tag_b, r_s2_tag_c;
    logic                 r_o_valid;
    logic [TAG_BITS-1:0]  r_o_tag_a, r_o_tag_b, r_o_tag_c;

    logic                 out_en;
    logic                 s2_en;
    logic signed [PW-1:0] n_p;
    logic signed [PW-1:0] n_q;

    assign out_en     = !r_o_valid || i_ready;
    assign s2_en      = !r_s2_valid || out_en;
    assign o_s1_ready = s2_en;

    assign n_p = PW'(i_d1) * PW'(i_d2);
    assign n_q = PW'(i_d3) * PW'(i_d4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (s2_en) begin
                r_s2_valid <= i_s1_valid;
            end
            if (out_en) begin
                // drop back-facing triangles
                r_o_valid <= r_s2_valid && (r_p >= r_q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_en && i_s1_valid) begin
            r_p        <= n_p;
            r_q        <= n_q;
            r_s2_tag_a <= i_tag_a;
            r_s2_tag_b <= i_tag_b;
            r_s2_tag_c <= i_tag_c;
        end
        if (out_en && r_s2_valid) begin
            r_o_tag_a <= r_s2_tag_a;
            r_o_tag_b <= r_s2_tag_b;
            r_o_tag_c <= r_s2_tag_c;
        end
    end

    assign o_valid = r_o_valid;
    assign o_tag_a = r_o_tag_a;
    assign o_tag_b = r_o_tag_b;
    assign o_tag_c = r_o_tag_c;

endmodule

// ----- sv/triangle_assembly_cull_core.sv -----
// ----------------------------------------------------------------------------
// triangle_assembly_cull_core
// Primitive assembly (list, strip, fan) with back-face culling.
// ----------------------------------------------------------------------------
// Takes one vertex per cycle and keeps up at that rate indefinitely when the
// result side is ready. A kept triangle reaches o_valid through the stage
// registers in order: the transaction of its last vertex registers the edge
// differences of the selected vertices, then both cross-product multiplies
// are registered, then the sign compare is registered into the result
// register. Each stage has its own valid and
// stalls only when the stage after it is full, so a waiting result does not
// block input while the pipeline has room. Culled triangles and vertices that
// complete no triangle produce no transaction. Write i_cfg_data only while the
// block is idle.
module triangle_assembly_cull_core #(
    parameter int COORD_BITS = 16,
    parameter int TAG_BITS   = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  tac_pkg::t_mode              i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic [TAG_BITS-1:0]         i_vertex_tag,
    input  logic                        i_restart,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [TAG_BITS-1:0]         o_tag_a,
    output logic [TAG_BITS-1:0]         o_tag_b,
    output logic [TAG_BITS-1:0]         o_tag_c
);
    import tac_pkg::*;

    logic                        w_s1_valid;
    logic                        w_s1_ready;
    logic signed [COORD_BITS:0]  w_d1, w_d2, w_d3, w_d4;
    logic [TAG_BITS-1:0]         w_tag_a, w_tag_b, w_tag_c;

    tac_assemble #(
        .COORD_BITS (COORD_BITS),
        .TAG_BITS   (TAG_BITS)
    ) u_assemble (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_vertex_tag (i_vertex_tag),
        .i_restart    (i_restart),
        .o_s1_valid   (w_s1_valid),
        .i_s1_ready   (w_s1_ready),
        .o_d1         (w_d1),
        .o_d2         (w_d2),
        .o_d3         (w_d3),
        .o_d4         (w_d4),
        .o_tag_a      (w_tag_a),
        .o_tag_b      (w_tag_b),
        .o_tag_c      (w_tag_c)
    );

    tac_cull #(
        .COORD_BITS (COORD_BITS),
        .TAG_BITS   (TAG_BITS)
    ) u_cull (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (w_s1_valid),
        .o_s1_ready (w_s1_ready),
        .i_d1       (w_d1),
        .i_d2       (w_d2),
        .i_d3       (w_d3),
        .i_d4       (w_d4),
        .i_tag_a    (w_tag_a),
        .i_tag_b    (w_tag_b),
        .i_tag_c    (w_tag_c),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_tag_a    (o_tag_a),
        .o_tag_b    (o_tag_b),
        .o_tag_c    (o_tag_c)
    );

    a_s1_from_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(w_s1_valid) |-> $past(i_valid && o_ready))
        else $error("triangle stage filled without an input transaction");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_valid && !w_s1_ready |=> w_s1_valid && $stable(w_tag_c))
        else $error("stalled triangle stage lost its contents");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !w_s1_valid)
        else $error("pipeline not empty after reset");

endmodule

// ----- tb/sv/tb_triangle_assembly_cull_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_cull_checker
// Watches the vertex, result and configuration ports of the assembly core,
// assembles triangles on its own copy of the batch state, applies the
// back-face test and compares every result transaction, field by field, with
// the oldest kept triangle still waiting. Reports the number of kept
// triangles still waiting and the number of failures.
// ----------------------------------------------------------------------------
module triangle_cull_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  tac_pkg::t_mode i_cfg_data,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  logic [15:0]    i_pos_x,
    input  logic [15:0]    i_pos_y,
    input  logic [15:0]    i_vertex_tag,
    input  logic           i_restart,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  logic [15:0]    i_tag_a,
    input  logic [15:0]    i_tag_b,
    input  logic [15:0]    i_tag_c,
    output int             o_pending,
    output int             o_errors
);

    import tac_pkg::*;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        tag;
    } t_vertex;

    typedef struct {
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
    } t_tri_tags;

    t_tri_tags   kept_tris [$];
    t_mode       mode;
    t_vertex     older;
    t_vertex     newer;
    t_vertex     anchor;
    logic [1:0]  seen;
    logic [1:0]  phase;
    logic        parity;
    int          err_count = 0;

    // Keep when the cross product of the edges from a to b and from a to c is not negative.
    function automatic bit faces_front(t_vertex a, t_vertex b, t_vertex c);
        longint p;
        longint q;
        p = (longint'(b.x) - longint'(a.x)) * (longint'(c.y) - longint'(a.y));
        q = (longint'(b.y) - longint'(a.y)) * (longint'(c.x) - longint'(a.x));
        return (p - q) >= 0;
    endfunction

    task automatic assemble_vertex(input t_vertex cur, input logic rs);
        t_vertex   va;
        t_vertex   vb;
        logic      form;
        t_tri_tags t;
        form = 1'b0;
        va   = older;
        vb   = newer;
        if (rs) begin
            seen   = '0;
            phase  = '0;
            parity = 1'b0;
        end
        case (mode)
            TOPO_LIST: begin
                form = (phase == PHASE_LAST) && (seen == SEEN_FULL);
            end
            TOPO_STRIP: begin
                form = (seen == SEEN_FULL);
                if (parity) begin
                    va = newer;
                    vb = older;
                end
            end
            TOPO_FAN: begin
                form = (seen == SEEN_FULL);
                va   = anchor;
            end
            default: form = 1'b0;
        endcase
        if (form && faces_front(va, vb, cur)) begin
            t.a = va.tag;
            t.b = vb.tag;
            t.c = cur.tag;
            kept_tris.push_back(t);
        end
        if (seen == 0)
            anchor = cur;
        if (seen == SEEN_FULL)
            parity = ~parity;
        phase = (phase >= PHASE_LAST) ? 2'd0 : phase + 2'd1;
        if (seen < SEEN_FULL)
            seen = seen + 2'd1;
        older = newer;
        newer = cur;
    endtask

    task automatic check_tag(input string name, input logic [15:0] want,
                             input logic [15:0] got);
        if (got !== want) begin
            $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_tri_tags want;
        t_vertex   cur;
        if (!i_rst_n) begin
            mode   = TOPO_LIST;
            older  = '{default: '0};
            newer  = '{default: '0};
            anchor = '{default: '0};
            seen   = '0;
            phase  = '0;
            parity = 1'b0;
            kept_tris.delete();
        end else begin
            if (i_cfg_we)
                mode = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                if (kept_tris.size() == 0) begin
                    $display("%0t unexpected triangle: expected none actual %h %h %h",
                             $time, i_tag_a, i_tag_b, i_tag_c);
                    err_count++;
                end else begin
                    want = kept_tris.pop_front();
                    check_tag("tag_a", want.a, i_tag_a);
                    check_tag("tag_b", want.b, i_tag_b);
                    check_tag("tag_c", want.c, i_tag_c);
                end
            end
            if (i_in_valid && i_in_ready) begin
                cur.x   = i_pos_x;
                cur.y   = i_pos_y;
                cur.tag = i_vertex_tag;
                assemble_vertex(cur, i_restart);
            end
        end
        o_pending <= kept_tris.size();
        o_errors  <= err_count;
    end

endmodule

// ----- tb/sv/tb_triangle_assembly_cull_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_triangle_assembly_cull_core
// Vertex stream stimulus for the triangle assembly and culling core.
// A short directed run covers coordinate and tag extremes and degenerate,
// front and back facing list triangles, strip, fan and unused topologies;
// then random batches per topology, most with random stalls on both channels.
// The checker beside the core predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_triangle_assembly_cull_core;

    import tac_pkg::*;

    localparam t_mode TOPO_NONE   = 2'd3;
    localparam int    PIPE_DRAIN  = 8;
    localparam int    NUM_PHASES  = 10;
    localparam int    PHASE_ITEMS = 155;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    t_mode       cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] vertex_tag;
    logic        restart;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] tag_a;
    logic [15:0] tag_b;
    logic [15:0] tag_c;
    int          pending;
    int          errors;

    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;

    t_mode phase_modes [NUM_PHASES] = '{TOPO_STRIP, TOPO_LIST, TOPO_FAN, TOPO_NONE,
        TOPO_LIST, TOPO_FAN, TOPO_STRIP, TOPO_FAN, TOPO_LIST, TOPO_STRIP};

    triangle_assembly_cull_core DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_valid      (in_valid),
        .o_ready      (in_ready),
        .i_pos_x      (pos_x),
        .i_pos_y      (pos_y),
        .i_vertex_tag (vertex_tag),
        .i_restart    (restart),
        .o_valid      (out_valid),
        .i_ready      (out_ready),
        .o_tag_a      (tag_a),
        .o_tag_b      (tag_b),
        .o_tag_c      (tag_c)
    );

    triangle_cull_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_pos_x      (pos_x),
        .i_pos_y      (pos_y),
        .i_vertex_tag (vertex_tag),
        .i_restart    (restart),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_tag_a      (tag_a),
        .i_tag_b      (tag_b),
        .i_tag_c      (tag_c),
        .o_pending    (pending),
        .o_errors     (errors)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Result side: stall in random bursts.
    initial begin
        int hold;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                hold = $urandom_range(1, 15);
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    function automatic logic [15:0] pick_coord();
        int v;
        case ($urandom_range(0, 9))
            0:       v = -32768;
            1:       v = 32767;
            2, 3:    v = $urandom_range(0, 32) - 16;
            4, 5, 6: v = $urandom_range(0, 2048) - 1024;
            default: v = $urandom;
        endcase
        return v[15:0];
    endfunction

    task automatic send_vertex(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] tag, input logic rs);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 15);
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        pos_x      <= x;
        pos_y      <= y;
        vertex_tag <= tag;
        restart    <= rs;
        @(posedge clk);
        while (!(in_valid && in_ready)) @(posedge clk);
    endtask

    // Hold the vertex side until every kept triangle is out and the pipe is empty.
    task automatic settle_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic write_mode(input t_mode m);
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        int          p;
        int          n;
        int          batch_left;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] last_x;
        logic [15:0] last_y;
        logic        rs;

        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_data   <= TOPO_LIST;
        in_valid   <= 1'b0;
        pos_x      <= '0;
        pos_y      <= '0;
        vertex_tag <= '0;
        restart    <= 1'b0;
        batch_left = 0;
        last_x     = '0;
        last_y     = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // list: degenerate keep, large front facing, large back facing
        write_mode(TOPO_LIST);
        send_vertex(16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_vertex(16'h7fff, 16'h7fff, 16'hffff, 1'b0);
        send_vertex(16'h8000, 16'h8000, 16'h0001, 1'b0);
        send_vertex(16'h8000, 16'h8000, 16'haaaa, 1'b0);
        send_vertex(16'h7fff, 16'h8000, 16'h5555, 1'b0);
        send_vertex(16'h8000, 16'h7fff, 16'hffff, 1'b0);
        send_vertex(16'h8000, 16'h8000, 16'h0002, 1'b0);
        send_vertex(16'h8000, 16'h7fff, 16'h0003, 1'b0);
        send_vertex(16'h7fff, 16'h8000, 16'h0004, 1'b0);
        settle_idle();

        // strip: alternating winding
        write_mode(TOPO_STRIP);
        send_vertex(16'h0000, 16'h0000, 16'h0010, 1'b1);
        send_vertex(16'h0010, 16'h0000, 16'h0011, 1'b0);
        send_vertex(16'h0000, 16'h0010, 16'h0012, 1'b0);
        send_vertex(16'h0010, 16'h0010, 16'h0013, 1'b0);
        send_vertex(16'h0000, 16'h0020, 16'h0014, 1'b0);
        send_vertex(16'h0030, 16'h0000, 16'h0015, 1'b0);
        settle_idle();

        // fan around the batch anchor
        write_mode(TOPO_FAN);
        send_vertex(16'h0000, 16'h0000, 16'h0020, 1'b1);
        send_vertex(16'h0040, 16'h0000, 16'h0021, 1'b0);
        send_vertex(16'h0040, 16'h0040, 16'h0022, 1'b0);
        send_vertex(16'h0000, 16'h0040, 16'h0023, 1'b0);
        send_vertex(16'hffc0, 16'h0000, 16'h0024, 1'b0);
        settle_idle();

        // unused topology code: history only
        write_mode(TOPO_NONE);
        send_vertex(16'h1234, 16'h5678, 16'h0030, 1'b1);
        send_vertex(16'h0000, 16'h0000, 16'h0031, 1'b0);
        send_vertex(16'h0111, 16'h0222, 16'h0032, 1'b0);

        for (p = 0; p < NUM_PHASES; p++) begin
            settle_idle();
            write_mode(phase_modes[p]);
            tx_idle_en = (p != 2) && (p != 6) && (p != NUM_PHASES - 1);
            rx_idle_en = tx_idle_en;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 4 && n == 70)
                    settle_idle();
                if (batch_left == 0) begin
                    batch_left = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2)
                                                              : $urandom_range(3, 14);
                    rs = 1'b1;
                end else begin
                    rs = ($urandom_range(0, 39) == 0);
                end
                batch_left--;
                if ($urandom_range(0, 11) == 0) begin
                    x = last_x;
                    y = last_y;
                end else begin
                    x = pick_coord();
                    y = pick_coord();
                end
                send_vertex(x, y, 16'($urandom), rs);
                last_x = x;
                last_y = y;
            end
        end
        settle_idle();

        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
